/* sv/lbe_pkg.sv */
// Package with the item types, status codes and constants of the Legendre basis evaluator.
`timescale 1ns / 1ps
package lbe_pkg;

  localparam int MAX_ORDER_DEF = 15;
  localparam int FRAC_BITS_DEF = 16;
  localparam int KDIV_STEPS    = 8;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OUTSIDE    = 2'd1;
  localparam logic [1:0] ST_ZERO_WIDTH = 2'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] elem_left;
    logic signed [31:0] elem_right;
    logic [30:0]        elem_width;
    logic [3:0]         poly_order;
    logic               want_derivative;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] basis_value;
    logic [1:0]         eval_status;
    logic               saturated;
  } out_item_t;

endpackage

/* sv/lbe_div.sv */
// Iterative restoring divider, unsigned, a configurable number of quotient bits per cycle.
`timescale 1ns / 1ps
module lbe_div #(
  parameter int NW    = 49,
  parameter int DVW   = 31,
  parameter int STEPS = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [NW-1:0]  quotient
);

  localparam int CNT = (NW + STEPS - 1) / STEPS;
  localparam int PW  = CNT * STEPS;
  localparam int CW  = $clog2(CNT + 1);

  logic [PW-1:0]  sh_r, sh_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DVW:0]   trial;

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      sh_nxt   = PW'(dividend);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(CNT);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < STEPS; i++) begin
        trial = {rem_nxt, sh_nxt[PW-1]};
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = DVW'(trial - {1'b0, dvs_r});
          sh_nxt  = {sh_nxt[PW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DVW-1:0];
          sh_nxt  = {sh_nxt[PW-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = sh_r[NW-1:0];

endmodule

/* sv/legendre_basis_evaluator_top.sv */
// Legendre basis evaluator top level: sequencer, multiplier and recurrence registers.
// Input beats (in_valid/in_ready, in_data) carry a point, the element bounds and width,
// the order and the value/derivative select. One result beat leaves on out_valid/out_ready.
// One item is worked on at a time; in_ready is high only while the sequencer is idle.
// A point outside the element or a zero width goes from S_CHK straight to S_DONE.
// Otherwise a 1-bit-per-cycle divider maps the point, then each recurrence order from
// 2 up runs a 32x32 multiply, rounding, combine, and an 8-bit-per-cycle divide by the order.
// A derivative result adds the Jacobian divide on the same 1-bit-per-cycle divider.
// The result sits in an output register; a new beat is taken while it waits, and the
// sequencer holds the next result until the receiver takes the pending one.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
`timescale 1ns / 1ps
module legendre_basis_evaluator_top
  import lbe_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int DW = 33 + FRAC_BITS;
  localparam int KW = (MAX_ORDER < 2) ? 2 : $clog2(MAX_ORDER + 1);
  localparam int TW = 65 - FRAC_BITS;
  localparam int NW = TW + KW + 2;
  localparam int EW = 34 + KW;

  localparam logic signed [31:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
  localparam logic [DW-1:0]      XS_LIM  = (DW'(1) << 31) + (DW'(1) << FRAC_BITS);
  localparam logic [DW-1:0]      LIM_D   = DW'(1) << 31;
  localparam logic [NW-1:0]      LIM_N   = NW'(1) << 31;
  localparam logic signed [64:0] RND_POS = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] RND_NEG = RND_POS - 65'sd1;
  localparam logic [KW-1:0]      MAX_K   = KW'(MAX_ORDER);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_MAP, S_MUL, S_RND, S_COMB, S_KGO, S_KDIV, S_FIN, S_JAC, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  in_item_t           in_r, in_nxt;
  logic [KW-1:0]      ord_r, ord_nxt, k_r, k_nxt, ord_in;
  logic signed [31:0] xs_r, xs_nxt, p0_r, p0_nxt, p1_r, p1_nxt;
  logic signed [31:0] d0_r, d0_nxt, d1_r, d1_nxt, dn_r, dn_nxt;
  logic signed [31:0] res_value_r, res_value_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               res_sat_r, res_sat_nxt;
  logic               pflag_r, pflag_nxt, dflag_r, dflag_nxt;
  logic               dclip_r, dclip_nxt, jneg_r, jneg_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [TW-1:0] t_r, t_nxt;
  logic signed [NW-1:0] n_r, n_nxt;

  logic signed [32:0]   diff;
  logic                 outside;
  logic [KW:0]          c2k1;
  logic signed [KW+1:0] c2k1_s;
  logic [KW-1:0]        km1;
  logic signed [KW:0]   km1_s;
  logic signed [EW-1:0] dsum;
  logic                 dclip_w;
  logic signed [31:0]   dn_w;
  logic signed [64:0]   rsum;
  logic [NW-1:0]        n_mag;
  logic signed [31:0]   dv;
  logic [31:0]          dv_mag;
  logic                 xs_base;
  logic signed [31:0]   xs_map;
  logic                 pclip;
  logic signed [31:0]   pn;
  logic                 jclip;
  logic signed [31:0]   jval;

  logic          ldiv_start, ldiv_done;
  logic [DW-1:0] ldiv_dividend, ldiv_quot;
  logic          kdiv_start, kdiv_done;
  logic [NW-1:0] kdiv_quot;

  lbe_div #(
    .NW    (DW),
    .DVW   (31),
    .STEPS (1)
  ) u_ldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ldiv_start),
    .dividend (ldiv_dividend),
    .divisor  (in_r.elem_width),
    .done     (ldiv_done),
    .quotient (ldiv_quot)
  );

  lbe_div #(
    .NW    (NW),
    .DVW   (KW),
    .STEPS (KDIV_STEPS)
  ) u_kdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kdiv_start),
    .dividend (n_mag),
    .divisor  (k_r),
    .done     (kdiv_done),
    .quotient (kdiv_quot)
  );

  assign ord_in  = (int'(in_data.poly_order) > MAX_ORDER) ? MAX_K : KW'(in_data.poly_order);
  assign diff    = {in_r.point_x[31], in_r.point_x} - {in_r.elem_left[31], in_r.elem_left};
  assign outside = (in_r.point_x > in_r.elem_right) || (in_r.point_x < in_r.elem_left);

  assign c2k1   = {k_r, 1'b0} - (KW + 1)'(1);
  assign c2k1_s = signed'({1'b0, c2k1});
  assign km1    = k_r - KW'(1);
  assign km1_s  = signed'({1'b0, km1});

  assign dsum    = d0_r + p1_r * c2k1_s;
  assign dclip_w = (dsum > EW'(S32_MAX)) || (dsum < EW'(S32_MIN));
  assign dn_w    = dclip_w ? (dsum[EW-1] ? S32_MIN : S32_MAX) : dsum[31:0];

  assign rsum  = prod_r + (prod_r[63] ? RND_NEG : RND_POS);
  assign n_mag = n_r[NW-1] ? unsigned'(-n_r) : unsigned'(n_r);

  assign dv     = (ord_r == '0) ? '0 : d1_r;
  assign dv_mag = dv[31] ? unsigned'(-dv) : unsigned'(dv);

  assign ldiv_dividend = (state_r == S_FIN) ? {dv_mag, {(FRAC_BITS + 1){1'b0}}}
                                            : {diff[31:0], {(FRAC_BITS + 1){1'b0}}};
  assign ldiv_start = (state_r == S_CHK && !outside && in_r.elem_width != '0) ||
                      (state_r == S_FIN && in_r.want_derivative);
  assign kdiv_start = (state_r == S_KGO);

  assign xs_base = (ldiv_quot >= XS_LIM);
  assign xs_map  = xs_base ? S32_MAX : signed'(ldiv_quot[31:0] - ONE_Q);

  assign pclip = n_r[NW-1] ? (kdiv_quot > LIM_N) : (kdiv_quot >= LIM_N);
  assign pn    = pclip ? (n_r[NW-1] ? S32_MIN : S32_MAX)
                       : (n_r[NW-1] ? -signed'(kdiv_quot[31:0]) : signed'(kdiv_quot[31:0]));

  assign jclip = jneg_r ? (ldiv_quot > LIM_D) : (ldiv_quot >= LIM_D);
  assign jval  = jclip ? (jneg_r ? S32_MIN : S32_MAX)
                       : (jneg_r ? -signed'(ldiv_quot[31:0]) : signed'(ldiv_quot[31:0]));

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    in_nxt         = in_r;
    ord_nxt        = ord_r;
    k_nxt          = k_r;
    xs_nxt         = xs_r;
    p0_nxt         = p0_r;
    p1_nxt         = p1_r;
    d0_nxt         = d0_r;
    d1_nxt         = d1_r;
    dn_nxt         = dn_r;
    dclip_nxt      = dclip_r;
    pflag_nxt      = pflag_r;
    dflag_nxt      = dflag_r;
    jneg_nxt       = jneg_r;
    prod_nxt       = prod_r;
    t_nxt          = t_r;
    n_nxt          = n_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_sat_nxt    = res_sat_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          ord_nxt   = ord_in;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (outside) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_OUTSIDE;
          res_sat_nxt    = 1'b0;
          state_nxt      = S_DONE;
        end else if (in_r.elem_width == '0) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_ZERO_WIDTH;
          res_sat_nxt    = 1'b0;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        if (ldiv_done) begin
          xs_nxt    = xs_map;
          p0_nxt    = ONE_Q;
          p1_nxt    = xs_map;
          d0_nxt    = '0;
          d1_nxt    = ONE_Q;
          pflag_nxt = xs_base;
          dflag_nxt = xs_base;
          k_nxt     = KW'(2);
          state_nxt = (ord_r >= KW'(2)) ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        prod_nxt  = xs_r * p1_r;
        dn_nxt    = dn_w;
        dclip_nxt = dclip_w;
        state_nxt = S_RND;
      end
      S_RND: begin
        t_nxt     = rsum[64:FRAC_BITS];
        state_nxt = S_COMB;
      end
      S_COMB: begin
        n_nxt     = t_r * c2k1_s - p0_r * km1_s;
        state_nxt = S_KGO;
      end
      S_KGO: begin
        state_nxt = S_KDIV;
      end
      S_KDIV: begin
        if (kdiv_done) begin
          p0_nxt    = p1_r;
          p1_nxt    = pn;
          d0_nxt    = d1_r;
          d1_nxt    = dn_r;
          dflag_nxt = dflag_r | pflag_r | dclip_r;
          pflag_nxt = pflag_r | pclip;
          k_nxt     = k_r + KW'(1);
          state_nxt = (k_r == ord_r) ? S_FIN : S_MUL;
        end
      end
      S_FIN: begin
        res_status_nxt = ST_OK;
        if (!in_r.want_derivative) begin
          res_value_nxt = (ord_r == '0) ? p0_r : p1_r;
          res_sat_nxt   = pflag_r;
          state_nxt     = S_DONE;
        end else begin
          jneg_nxt  = dv[31];
          state_nxt = S_JAC;
        end
      end
      S_JAC: begin
        if (ldiv_done) begin
          res_value_nxt = jval;
          res_sat_nxt   = dflag_r | jclip;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.basis_value = res_value_r;
          out_data_nxt.eval_status = res_status_r;
          out_data_nxt.saturated   = res_sat_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r         <= in_nxt;
    ord_r        <= ord_nxt;
    k_r          <= k_nxt;
    xs_r         <= xs_nxt;
    p0_r         <= p0_nxt;
    p1_r         <= p1_nxt;
    d0_r         <= d0_nxt;
    d1_r         <= d1_nxt;
    dn_r         <= dn_nxt;
    dclip_r      <= dclip_nxt;
    pflag_r      <= pflag_nxt;
    dflag_r      <= dflag_nxt;
    jneg_r       <= jneg_nxt;
    prod_r       <= prod_nxt;
    t_r          <= t_nxt;
    n_r          <= n_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_sat_r    <= res_sat_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.eval_status != ST_OK |->
      out_data.basis_value == '0 && !out_data.saturated)
    else $error("non-evaluated beat carries a value or saturation");

  a_ldiv_done: assert property (@(posedge clk) disable iff (!rst_n)
    ldiv_done |-> state_r == S_MAP || state_r == S_JAC)
    else $error("long divider finished outside a wait state");

  a_kdiv_done: assert property (@(posedge clk) disable iff (!rst_n)
    kdiv_done |-> state_r == S_KDIV)
    else $error("order divider finished outside its wait state");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> k_r >= KW'(2) && k_r <= ord_r)
    else $error("recurrence order out of range");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the Legendre basis evaluator: directed table, random items, predictor.
`timescale 1ns / 1ps
module tb;
  import lbe_pkg::*;

  localparam int RANDOM_ITEMS   = 1880;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 300;

  localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] Q_TWO  = 32'sh0002_0000;
  localparam logic signed [31:0] Q_HALF = 32'sh0000_8000;
  localparam logic [30:0]        W_ONE  = 31'h0001_0000;
  localparam logic [30:0]        W_TWO  = 31'h0002_0000;
  localparam logic [30:0]        W_MAX  = 31'h7fff_ffff;
  localparam longint             Q_UNIT = 64'sd1 <<< FRAC_BITS_DEF;

  localparam out_item_t R_OUTSIDE = '{32'sd0, ST_OUTSIDE, 1'b0};
  localparam out_item_t R_ZERO_W  = '{32'sd0, ST_ZERO_WIDTH, 1'b0};

  typedef longint unsigned u64_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_CHOKE} rx_mode_t;

  typedef struct {
    in_item_t  item;
    logic      known;
    out_item_t result;
  } eval_request_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  eval_request_t eval_requests[$];
  eval_request_t cur_request;
  out_item_t     pending_results[$];
  out_item_t     want;
  int            fail_count = 0;
  int            idle_cycles = 0;
  rx_mode_t      rx_mode = RX_STEADY;
  int unsigned   rx_left = 0;

  legendre_basis_evaluator_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clip_s32(longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_item_t eval_legendre(in_item_t it);
    longint            x, lo, hi, xs, p_prev, p_cur, d_prev, d_cur;
    longint            prod, p_next, d_next, dv, kk, val;
    u64_t              w, q, mag, quo;
    int unsigned       ord;
    bit                neg, p_sat, d_sat, sat;
    out_item_t         res;
    x   = longint'($signed(it.point_x));
    lo  = longint'($signed(it.elem_left));
    hi  = longint'($signed(it.elem_right));
    w   = u64_t'(it.elem_width);
    ord = it.poly_order;
    if (ord > MAX_ORDER_DEF) begin
      ord = MAX_ORDER_DEF;
    end
    res = '{32'sd0, ST_OK, 1'b0};
    if (x > hi || x < lo) begin
      res.eval_status = ST_OUTSIDE;
      return res;
    end
    if (w == 0) begin
      res.eval_status = ST_ZERO_WIDTH;
      return res;
    end
    // map onto [-1,1]; an oversized quotient clips and taints both chains
    q     = (u64_t'(x - lo) << (FRAC_BITS_DEF + 1)) / w;
    p_sat = (q >= 64'd2147483648 + u64_t'(Q_UNIT));
    xs    = p_sat ? 64'sd2147483647 : longint'(q) - Q_UNIT;
    d_sat = p_sat;
    p_prev = Q_UNIT;
    p_cur  = xs;
    d_prev = 64'sd0;
    d_cur  = Q_UNIT;
    for (int k = 2; k <= ord; k++) begin
      kk   = k;
      prod = xs * p_cur;
      neg  = prod < 0;
      mag  = neg ? u64_t'(-prod) : u64_t'(prod);
      mag  = (mag + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
      prod = neg ? -longint'(mag) : longint'(mag);
      d_sat  = d_sat | p_sat;
      p_next = clip_s32(((2 * kk - 1) * prod - (kk - 1) * p_prev) / kk, p_sat);
      d_next = clip_s32(d_prev + (2 * kk - 1) * p_cur, d_sat);
      p_prev = p_cur;
      p_cur  = p_next;
      d_prev = d_cur;
      d_cur  = d_next;
    end
    if (!it.want_derivative) begin
      val = (ord == 0) ? p_prev : p_cur;
      sat = p_sat;
    end else begin
      // Jacobian 2/width, truncated toward zero on the magnitude
      dv  = (ord == 0) ? 64'sd0 : d_cur;
      neg = dv < 0;
      mag = neg ? u64_t'(-dv) : u64_t'(dv);
      quo = (mag << (FRAC_BITS_DEF + 1)) / w;
      if (quo > 64'd2147483647 + (neg ? 64'd1 : 64'd0)) begin
        d_sat = 1'b1;
        val   = neg ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
        val = neg ? -longint'(quo) : longint'(quo);
      end
      sat = d_sat;
    end
    res.basis_value = val[31:0];
    res.saturated   = sat;
    return res;
  endfunction

  function automatic in_item_t pack_point(logic signed [31:0] x, lo, hi, logic [30:0] w,
                                          logic [3:0] ord, logic der);
    in_item_t it;
    it.point_x         = x;
    it.elem_left       = lo;
    it.elem_right      = hi;
    it.elem_width      = w;
    it.poly_order      = ord;
    it.want_derivative = der;
    return it;
  endfunction

  function automatic void add_request(in_item_t it, logic known = 1'b0,
                                      out_item_t result = '0);
    eval_request_t r;
    r.item   = it;
    r.known  = known;
    r.result = result;
    eval_requests.push_back(r);
  endfunction

  // receiver: steady, coin-flip and choked stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(4, 64);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STEADY: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // scoreboard and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: basis_value %0d eval_status %0d sat %0d",
                 out_data.basis_value, out_data.eval_status, out_data.saturated);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.basis_value !== want.basis_value) begin
            $error("basis_value: expected %0d, actual %0d",
                   want.basis_value, out_data.basis_value);
            fail_count++;
          end
          if (out_data.eval_status !== want.eval_status) begin
            $error("eval_status: expected %0d, actual %0d",
                   want.eval_status, out_data.eval_status);
            fail_count++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, out_data.saturated);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(cur_request.known ? cur_request.result
                                                    : eval_legendre(in_data));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("legendre_basis_evaluator_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    in_item_t    it;
    longint      x, lo, hi, span;
    int unsigned sel, mag, gap, burst_left;

    add_request(pack_point(-Q_ONE, 0, Q_TWO, W_TWO, 4'd3, 1'b0), 1'b1, R_OUTSIDE);
    add_request(pack_point(Q_TWO + Q_ONE, 0, Q_TWO, W_TWO, 4'd15, 1'b1), 1'b1, R_OUTSIDE);
    add_request(pack_point(Q_ONE, Q_TWO, 0, W_TWO, 4'd2, 1'b0), 1'b1, R_OUTSIDE);
    add_request(pack_point(S32_MIN, S32_MIN + 1, S32_MAX, W_MAX, 4'd15, 1'b1), 1'b1,
                R_OUTSIDE);
    add_request(pack_point(Q_ONE, 0, Q_TWO, '0, 4'd4, 1'b0), 1'b1, R_ZERO_W);
    add_request(pack_point(S32_MAX, S32_MIN, S32_MAX, '0, 4'd15, 1'b1), 1'b1, R_ZERO_W);
    add_request(pack_point(Q_HALF, 0, Q_TWO, W_TWO, 4'd0, 1'b0), 1'b1,
                '{Q_ONE, ST_OK, 1'b0});
    add_request(pack_point(Q_HALF, 0, Q_TWO, W_TWO, 4'd0, 1'b1), 1'b1,
                '{32'sd0, ST_OK, 1'b0});
    add_request(pack_point(0, 0, Q_TWO, W_TWO, 4'd1, 1'b0), 1'b1, '{-Q_ONE, ST_OK, 1'b0});
    add_request(pack_point(Q_ONE, 0, Q_TWO, W_TWO, 4'd1, 1'b1), 1'b1, '{Q_ONE, ST_OK, 1'b0});
    add_request(pack_point(S32_MAX, 0, S32_MAX, 31'd1, 4'd1, 1'b0), 1'b1,
                '{S32_MAX, ST_OK, 1'b1});
    add_request(pack_point(0, 0, Q_TWO, W_TWO, 4'd15, 1'b0));
    add_request(pack_point(0, 0, Q_TWO, W_TWO, 4'd15, 1'b1));
    add_request(pack_point(Q_TWO, 0, Q_TWO, W_TWO, 4'd15, 1'b0));
    add_request(pack_point(Q_TWO, 0, Q_TWO, W_TWO, 4'd15, 1'b1));
    add_request(pack_point(0, S32_MIN, S32_MAX, W_MAX, 4'd15, 1'b1));
    add_request(pack_point(S32_MAX, S32_MIN, S32_MAX, 31'd1, 4'd15, 1'b1));
    add_request(pack_point(Q_ONE, 0, Q_TWO, 31'd1, 4'd2, 1'b1));
    add_request(pack_point(-Q_ONE - Q_HALF, -Q_TWO, -Q_ONE, W_ONE, 4'd7, 1'b1));
    add_request(pack_point(Q_ONE + 123, Q_ONE, Q_ONE + 4000, W_MAX, 4'd14, 1'b0));
    add_request(pack_point(S32_MIN, S32_MIN, S32_MIN, W_ONE, 4'd9, 1'b1));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel  = $urandom_range(0, 99);
      mag  = $urandom_range(1, 31);
      span = longint'($urandom & ((32'd1 << mag) - 1));
      lo   = longint'($urandom_range(0, 32'hffff_ffff - 32'(span))) - 64'sd2147483648;
      hi   = lo + span;
      x    = lo + longint'($urandom_range(0, 32'(span)));
      it.point_x         = x[31:0];
      it.elem_left       = lo[31:0];
      it.elem_right      = hi[31:0];
      it.elem_width      = span[30:0];
      it.poly_order      = 4'($urandom_range(0, 15));
      it.want_derivative = 1'($urandom_range(0, 1));
      if (sel >= 92) begin
        it.point_x    = $urandom;
        it.elem_left  = $urandom;
        it.elem_right = $urandom;
        it.elem_width = 31'($urandom);
      end else if (sel >= 88) begin
        it.elem_width = '0;
      end else if (sel >= 80) begin
        it.point_x = $urandom;
        if (sel[0]) begin
          it.elem_left  = hi[31:0];
          it.elem_right = lo[31:0];
        end
      end else if (sel >= 70) begin
        // width disagrees with the bounds
        it.elem_width = 31'($urandom);
      end
      add_request(it);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = 0;
    foreach (eval_requests[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      in_data     <= eval_requests[i].item;
      cur_request <= eval_requests[i];
      in_valid    <= 1'b1;
      @(posedge clk);
      while (!(in_valid && in_ready)) @(posedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("legendre_basis_evaluator_top regression: pass");
    end else begin
      $display("legendre_basis_evaluator_top regression: fail");
    end
    $finish;
  end

endmodule
